// File: hw/rtl/mlr_pkg.sv
`default_nettype none

package mlr_pkg;

  // Coordinate width of the raster and the derived decision variable width.
  localparam int CoordBits = 6;
  localparam int DecBits   = CoordBits + 4;
  localparam int ColorBits = 24;

  typedef logic [CoordBits-1:0]      coord_t;
  typedef logic signed [DecBits-1:0] dec_t;
  typedef logic [ColorBits-1:0]      color_t;

  // One line segment as it enters the block.
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } line_t;

  // One emitted pixel.
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_rgb;
    logic   last_pixel;
  } pixel_t;

endpackage

`default_nettype wire

// File: hw/rtl/mlr_intf.sv
`default_nettype none

// Line segment channel.
interface mlr_line_if;
  logic           valid;
  logic           ready;
  mlr_pkg::line_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Pixel channel.
interface mlr_pixel_if;
  logic            valid;
  logic            ready;
  mlr_pkg::pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Color register write channel.
interface mlr_cfg_if;
  logic            valid;
  logic            ready;
  mlr_pkg::color_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/midpoint_line_rasterizer.sv
`default_nettype none

// Midpoint line rasterizer. A line item carries two endpoints; the block
// orders them so that x does not decrease (equal x keeps the input order)
// and emits every pixel of the segment in order on the pixel channel, the
// final one with last_pixel set. Every pixel carries the color register,
// which is written through the configuration channel and should only be
// changed while no line is in progress. A line passes a setup state, then
// a walk state that emits max(dx, |dy|) + 1 pixels, 1 to 64 in all; the
// walk advances one pixel per cycle while the pixel sink does not stall,
// through a single shared decision adder. The line channel is ready only
// in the idle state, not in setup or walk; it reopens in the cycle after the
// last pixel enters the output register, even if that pixel is still waiting.
module midpoint_line_rasterizer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mlr_line_if.sink   line_i,
  mlr_pixel_if.source pixel_o,
  mlr_cfg_if.sink    cfg_i
);
  import mlr_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StWalk
  } state_e;

  localparam coord_t CoordOne = coord_t'(1);

  function automatic dec_t ext_coord(coord_t c);
    return $signed({{(DecBits-CoordBits){1'b0}}, c});
  endfunction

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  color_t color_q, color_d;

  line_t  line_q, line_d;
  coord_t cur_x_q, cur_x_d;
  coord_t cur_y_q, cur_y_d;
  dec_t   decision_q, decision_d;
  dec_t   step_major_q, step_major_d;
  dec_t   step_diag_q, step_diag_d;
  coord_t stop_q, stop_d;
  logic [1:0] octant_q, octant_d;
  pixel_t out_q, out_d;

  // Setup arithmetic signals.
  logic   swap;
  coord_t lo_x, lo_y, hi_x, hi_y;
  dec_t   dx, dy, ady, diag_rise, diag_fall;
  logic   falling, steep;

  // Walk signals.
  coord_t major_coord;
  logic   at_last, take_diag, load_out;
  dec_t   dec_inc;

  assign line_i.ready = (state_q == StIdle);
  assign cfg_i.ready  = 1'b1;
  assign pixel_o.valid = out_valid_q;
  assign pixel_o.data  = out_q;

  // Endpoint ordering and the initial decision terms.
  always_comb begin
    swap = line_q.end_x < line_q.start_x;
    lo_x = swap ? line_q.end_x : line_q.start_x;
    lo_y = swap ? line_q.end_y : line_q.start_y;
    hi_x = swap ? line_q.start_x : line_q.end_x;
    hi_y = swap ? line_q.start_y : line_q.end_y;
    dx = ext_coord(hi_x) - ext_coord(lo_x);
    dy = ext_coord(hi_y) - ext_coord(lo_y);
    falling = dy[DecBits-1];
    ady = falling ? -dy : dy;
    steep = ady >= dx;
    diag_rise = (dy - dx) <<< 1;
    diag_fall = (dy + dx) <<< 1;
  end

  // Per-pixel decision step shared by all four octant cases.
  always_comb begin
    major_coord = octant_q[0] ? cur_y_q : cur_x_q;
    at_last     = (major_coord == stop_q);
    take_diag   = (decision_q > 0) ^ (octant_q[1] ^ octant_q[0]);
    dec_inc     = take_diag ? step_diag_q : step_major_q;
    load_out    = (state_q == StWalk) && (!out_valid_q || pixel_o.ready);
  end

  // Next-state logic.
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    color_d      = color_q;
    line_d       = line_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    decision_d   = decision_q;
    step_major_d = step_major_q;
    step_diag_d  = step_diag_q;
    stop_d       = stop_q;
    octant_d     = octant_q;
    out_d        = out_q;

    if (cfg_i.valid) begin
      color_d = cfg_i.data;
    end

    if (out_valid_q && pixel_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (line_i.valid) begin
          line_d  = line_i.data;
          state_d = StSetup;
        end
      end
      StSetup: begin
        cur_x_d  = lo_x;
        cur_y_d  = lo_y;
        octant_d = {falling, steep};
        stop_d   = steep ? hi_y : hi_x;
        if (!falling) begin
          step_diag_d = diag_rise;
          if (steep) begin
            step_major_d = -(dx <<< 1);
            decision_d   = dy - (dx <<< 1);
          end else begin
            step_major_d = dy <<< 1;
            decision_d   = (dy <<< 1) - dx;
          end
        end else begin
          step_diag_d = diag_fall;
          if (steep) begin
            step_major_d = dx <<< 1;
            decision_d   = dy + (dx <<< 1);
          end else begin
            step_major_d = dy <<< 1;
            decision_d   = (dy <<< 1) + dx;
          end
        end
        state_d = StWalk;
      end
      StWalk: begin
        if (load_out) begin
          out_valid_d       = 1'b1;
          out_d.pixel_x     = cur_x_q;
          out_d.pixel_y     = cur_y_q;
          out_d.pixel_rgb   = color_q;
          out_d.last_pixel  = at_last;
          if (at_last) begin
            state_d = StIdle;
          end else begin
            decision_d = decision_q + dec_inc;
            // Major axis always moves; the minor axis moves on a diagonal step.
            if (octant_q[0]) begin
              cur_y_d = octant_q[1] ? cur_y_q - CoordOne : cur_y_q + CoordOne;
              if (take_diag) begin
                cur_x_d = cur_x_q + CoordOne;
              end
            end else begin
              cur_x_d = cur_x_q + CoordOne;
              if (take_diag) begin
                cur_y_d = octant_q[1] ? cur_y_q - CoordOne : cur_y_q + CoordOne;
              end
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state, output valid and the color register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      color_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      color_q     <= color_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    line_q       <= line_d;
    cur_x_q      <= cur_x_d;
    cur_y_q      <= cur_y_d;
    decision_q   <= decision_d;
    step_major_q <= step_major_d;
    step_diag_q  <= step_diag_d;
    stop_q       <= stop_d;
    octant_q     <= octant_d;
    out_q        <= out_d;
  end

`ifndef NO_ASSERTIONS
  // An accepted line always goes through the setup cycle next.
  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_i.valid && line_i.ready |=> state_q == StSetup)
    else $error("line accepted without entering setup");

  // On a shallow line the walk never passes the stop column.
  a_shallow_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWalk && !octant_q[0] |-> cur_x_q <= stop_q)
    else $error("shallow walk passed the end of the line");

  // A pixel that is not the last one leaves more of the line to walk.
  a_more_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_o.valid && !pixel_o.data.last_pixel |-> state_q == StWalk)
    else $error("non-final pixel emitted with no walk in progress");
`endif

endmodule

`default_nettype wire
